// ----- rtl/core/rkbx_pkg.sv -----
package rkbx_pkg;

    localparam int KEY_BYTES = 16;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;

    // Register indexes, at byte address 8 * index.
    localparam logic [2:0] REG_KEY_A_LO   = 3'd0;
    localparam logic [2:0] REG_KEY_A_HI   = 3'd1;
    localparam logic [2:0] REG_KEY_B_LO   = 3'd2;
    localparam logic [2:0] REG_KEY_B_HI   = 3'd3;
    localparam logic [2:0] REG_START_KEY  = 3'd4;
    localparam logic [2:0] REG_START_PA   = 3'd5;
    localparam logic [2:0] REG_START_PB   = 3'd6;
    localparam logic [2:0] REG_START_SWAP = 3'd7;

    // Position limits of the update rule.
    localparam logic [4:0] PA_LAST       = 5'h0F;
    localparam logic [4:0] PB_WRAP_LIMIT = 5'h0C;
    localparam logic [4:0] PB_SEED_LIMIT = 5'h08;
    localparam logic [6:0] KEY_NUM_STEP  = 7'd2;
    localparam logic [3:0] SEED_B_OFFSET = 4'd2;
    localparam logic [3:0] SEED_A_OFFSET = 4'd3;

    // Reciprocals that are exact for every 7-bit dividend.
    localparam logic [7:0] RECIP7  = 8'd147;   // 2^10 / 7, rounded up
    localparam logic [7:0] RECIP12 = 8'd171;   // 2^11 / 12, rounded up

    typedef struct packed {
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [6:0]       start_key_number;
        logic [3:0]       start_pos_a;
        logic [3:0]       start_pos_b;
        logic             start_swap;
    } cfg_t;

    typedef struct packed {
        logic [6:0] key_number;
        logic [3:0] pos_a;
        logic [3:0] pos_b;
        logic       swap_flag;
    } key_state_t;

    function automatic logic [2:0] mod7(input logic [6:0] k);
        logic [14:0] prod;
        logic [4:0]  q;
        logic [6:0]  r;
        prod = k * RECIP7;
        q    = prod[14:10];
        r    = k - 7'(q) * 7'd7;
        return r[2:0];
    endfunction

    function automatic logic [3:0] mod12(input logic [6:0] k);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = k * RECIP12;
        q    = prod[14:11];
        r    = k - 7'(q) * 7'd12;
        return r[3:0];
    endfunction

    function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                             input logic [3:0] idx);
        return key[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ----- rtl/core/rkbx_cfg_regs.sv -----
module rkbx_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rkbx_pkg::ADDR_W-1:0] paddr,
    input  logic [rkbx_pkg::DATA_W-1:0] pwdata,
    output logic [rkbx_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output rkbx_pkg::cfg_t              cfg
);

    rkbx_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[5:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end
        else if (wr_en) begin
            case (idx)
                rkbx_pkg::REG_KEY_A_LO:   cfg_reg.key_a[63:0]      <= pwdata;
                rkbx_pkg::REG_KEY_A_HI:   cfg_reg.key_a[127:64]    <= pwdata;
                rkbx_pkg::REG_KEY_B_LO:   cfg_reg.key_b[63:0]      <= pwdata;
                rkbx_pkg::REG_KEY_B_HI:   cfg_reg.key_b[127:64]    <= pwdata;
                rkbx_pkg::REG_START_KEY:  cfg_reg.start_key_number <= pwdata[6:0];
                rkbx_pkg::REG_START_PA:   cfg_reg.start_pos_a      <= pwdata[3:0];
                rkbx_pkg::REG_START_PB:   cfg_reg.start_pos_b      <= pwdata[3:0];
                rkbx_pkg::REG_START_SWAP: cfg_reg.start_swap       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            rkbx_pkg::REG_KEY_A_LO:   prdata = cfg_reg.key_a[63:0];
            rkbx_pkg::REG_KEY_A_HI:   prdata = cfg_reg.key_a[127:64];
            rkbx_pkg::REG_KEY_B_LO:   prdata = cfg_reg.key_b[63:0];
            rkbx_pkg::REG_KEY_B_HI:   prdata = cfg_reg.key_b[127:64];
            rkbx_pkg::REG_START_KEY:  prdata = {57'd0, cfg_reg.start_key_number};
            rkbx_pkg::REG_START_PA:   prdata = {60'd0, cfg_reg.start_pos_a};
            rkbx_pkg::REG_START_PB:   prdata = {60'd0, cfg_reg.start_pos_b};
            rkbx_pkg::REG_START_SWAP: prdata = {63'd0, cfg_reg.start_swap};
            default:                  prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/rkbx_keystream.sv -----
module rkbx_keystream (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   first_of_file,
    input  rkbx_pkg::cfg_t         cfg,
    output rkbx_pkg::key_state_t   cur,
    output rkbx_pkg::key_state_t   held
);

    rkbx_pkg::key_state_t state_reg;
    rkbx_pkg::key_state_t state_next;
    logic [4:0]           pa;
    logic [4:0]           pb;
    logic [6:0]           k;

    // A first word of a file runs from the start registers, not the held state.
    always_comb begin
        if (first_of_file) begin
            cur.key_number = cfg.start_key_number;
            cur.pos_a      = cfg.start_pos_a;
            cur.pos_b      = cfg.start_pos_b;
            cur.swap_flag  = cfg.start_swap;
        end
        else begin
            cur = state_reg;
        end
    end

    assign held = state_reg;

    always_comb begin
        pa         = {1'b0, cur.pos_a} + 5'd1;
        pb         = {1'b0, cur.pos_b} + 5'd1;
        k          = cur.key_number + rkbx_pkg::KEY_NUM_STEP;
        state_next = cur;
        if (pa <= rkbx_pkg::PA_LAST) begin
            state_next.pos_a = pa[3:0];
            if (pb > rkbx_pkg::PB_WRAP_LIMIT) begin
                state_next.pos_b     = 4'd0;
                state_next.swap_flag = !cur.swap_flag;
            end
            else begin
                state_next.pos_b = pb[3:0];
            end
        end
        else if (pb <= rkbx_pkg::PB_SEED_LIMIT) begin
            state_next.pos_a     = 4'd0;
            state_next.pos_b     = pb[3:0];
            state_next.swap_flag = !cur.swap_flag;
        end
        else begin
            // Both positions ran out: step the key number and re-seed.
            state_next.key_number = k;
            if (cur.swap_flag) begin
                state_next.pos_a     = {1'b0, rkbx_pkg::mod7(k)};
                state_next.pos_b     = rkbx_pkg::mod12(k) + rkbx_pkg::SEED_B_OFFSET;
                state_next.swap_flag = 1'b0;
            end
            else begin
                state_next.pos_b     = {1'b0, rkbx_pkg::mod7(k)};
                state_next.pos_a     = rkbx_pkg::mod12(k) + rkbx_pkg::SEED_A_OFFSET;
                state_next.swap_flag = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= '0;
        end
        else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/rolling_key_byte_xor_cipher_core.sv -----
// Rolling-key byte cipher: a byte is XORed with the key number and a key B byte,
// nibble-swapped while the swap flag is set, then XORed with a key A byte. Load
// the two 16-byte keys and the start counters over the register port, then send
// bytes; mark the first byte of each file with first_of_file so the key number,
// positions and swap flag are reloaded from the start registers. The core takes
// one word per clock and delivers each result from its output register in the
// cycle after acceptance; the key state steps on each accepted byte, so the rate
// is one byte per cycle while the output side does not stall. A stalled result
// holds the input side back only while the output register is full and stalled.
module rolling_key_byte_xor_cipher_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rkbx_pkg::ADDR_W-1:0] paddr,
    input  logic [rkbx_pkg::DATA_W-1:0] pwdata,
    output logic [rkbx_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  in_byte,
    input  logic                        first_of_file,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_byte
);

    rkbx_pkg::cfg_t       cfg;
    rkbx_pkg::key_state_t cur;
    rkbx_pkg::key_state_t held;
    logic                 accept;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic [7:0]           out_byte_next;
    logic [7:0]           mixed;
    logic [7:0]           swapped;

    rkbx_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rkbx_keystream u_keys (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .first_of_file (first_of_file),
        .cfg           (cfg),
        .cur           (cur),
        .held          (held)
    );

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb begin
        mixed         = in_byte ^ {1'b0, cur.key_number}
                        ^ rkbx_pkg::key_byte(cfg.key_b, cur.pos_b);
        swapped       = cur.swap_flag ? {mixed[3:0], mixed[7:4]} : mixed;
        out_byte_next = swapped ^ rkbx_pkg::key_byte(cfg.key_a, cur.pos_a);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            out_byte_reg <= out_byte_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // Every accepted word shows up at the output on the next cycle.
    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word did not reach the output register");

    // No word appears without an accepted input or a held, stalled one.
    a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
        !accept && !(out_valid && out_stall) |=> !out_valid)
        else $error("output word appeared without an accepted input");

    // The key number does not move on an accepted word that starts no file while position A has not run out.
    a_key_number_steps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !first_of_file && held.pos_a != 4'hF |=>
        held.key_number == $past(held.key_number))
        else $error("key number changed before key A position ran out");

    // Without an accepted word the key state stays put.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> held == $past(held))
        else $error("key state changed without an accepted word");

endmodule
